### sv/sba_pkg.sv
// ----------------------------------------------------------------------------
// sba_pkg - shared constants of the screen blend compositor
// Stage numbering of the pixel pipeline and configuration register indexes.
// ----------------------------------------------------------------------------
package sba_pkg;

    // Pipeline stage numbers, counted from the input register
    localparam int ST_IN   = 0;  // input word registered
    localparam int ST_MUL  = 1;  // first products
    localparam int ST_CA0  = 2;  // alpha times opacity, rounded
    localparam int ST_MSK  = 3;  // mask product
    localparam int ST_CA   = 4;  // composite alpha
    localparam int ST_NAM  = 5;  // (1 - base alpha) * composite alpha
    localparam int ST_NA   = 6;  // new alpha
    localparam int ST_DIV  = 7;  // dividend loaded into the divider
    localparam int ST_DIV0 = 8;  // first quotient bit stage

    // Stages besides the one-bit-per-stage divider, output register included
    localparam int EXTRA_STAGES = 9;

    localparam int CFG_IDX_BITS = 1;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        CFG_OPACITY = 1'b0,
        CFG_MASK_EN = 1'b1
    } t_cfg_reg;

endpackage

### sv/screen_blend_alpha_composite.sv
// ----------------------------------------------------------------------------
// screen_blend_alpha_composite - screen blend with alpha compositing
// Blends one RGBA layer pixel over one RGBA base pixel per word.
// ----------------------------------------------------------------------------
// Takes one base/layer/mask pixel per clock and returns one blended pixel per
// clock when the output side keeps up. The depth of the pixel pipeline is set
// by the restoring divider that scales each
// colour channel by composite alpha / new alpha: it resolves one quotient bit
// per register stage, in each of the three colour lanes. Ahead of it sit
// eight stages (input register, the opacity, mask and new-alpha products,
// each followed by its rounding stage, dividend load), and one output
// register follows it. Every stage has its own valid bit and stalls only when
// the stage after it is full and held, so bubbles are squeezed out and new
// words keep entering while a finished pixel waits on a stalled output.
// Channels are unsigned fractions with all ones meaning 1.0; rounding is to
// nearest, results saturate at 1.0, and a pixel whose composite or new alpha
// is zero passes the base colour through. Output alpha is the base alpha. The
// configuration port is always ready; write it only with the pipeline empty.
// ----------------------------------------------------------------------------
module screen_blend_alpha_composite #(
    parameter int CHANNEL_BITS = 16
) (
    input  logic                                       i_clk,
    input  logic                                       i_rst_n,
    // configuration write channel
    input  logic                                       i_cfg_valid,
    output logic                                       o_cfg_ready,
    input  logic [sba_pkg::CFG_IDX_BITS-1:0]           i_cfg_index,
    input  logic [CHANNEL_BITS-1:0]                    i_cfg_data,
    // pixel input
    input  logic                                       i_s_axis_tvalid,
    output logic                                       o_s_axis_tready,
    // base_red, base_green, base_blue, base_alpha, layer_red, layer_green,
    // layer_blue, layer_alpha, mask_value; zero padded to whole bytes
    input  logic [((9*CHANNEL_BITS+7)/8)*8-1:0]        i_s_axis_tdata,
    input  logic                                       i_s_axis_tlast,  // last_in
    // pixel output
    output logic                                       o_m_axis_tvalid,
    input  logic                                       i_m_axis_tready,
    // out_red, out_green, out_blue, out_alpha; zero padded to whole bytes
    output logic [((4*CHANNEL_BITS+7)/8)*8-1:0]        o_m_axis_tdata,
    output logic                                       o_m_axis_tlast   // last_out
);

    import sba_pkg::*;

    localparam int N     = CHANNEL_BITS;
    localparam int L     = CHANNEL_BITS + EXTRA_STAGES;
    localparam int OUT_W = ((4*CHANNEL_BITS+7)/8)*8;
    localparam logic [N-1:0] ONE = {N{1'b1}};

    // ---------------- configuration registers ----------------
    logic [N-1:0] r_opacity;
    logic         r_mask_en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_opacity <= ONE;
            r_mask_en <= 1'b0;
        end else if (i_cfg_valid) begin
            unique case (t_cfg_reg'(i_cfg_index))
                CFG_OPACITY: r_opacity <= i_cfg_data;
                CFG_MASK_EN: r_mask_en <= i_cfg_data[0];
                default:     r_opacity <= r_opacity;
            endcase
        end
    end

    assign o_cfg_ready = 1'b1;

    // ---------------- stage valid bits and flow control ----------------
    // A stage loads when it is empty or its word moves on this cycle.
    logic [L-1:0] r_v;
    logic [L:0]   rdy;
    logic [L-1:0] en;

    assign rdy[L] = i_m_axis_tready;
    for (genvar k = 0; k < L; k++) begin : g_rdy
        assign rdy[k] = !r_v[k] || rdy[k+1];
    end
    assign en = rdy[L-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (en[0]) begin
                r_v[0] <= i_s_axis_tvalid;
            end
            for (int k = 1; k < L; k++) begin
                if (en[k]) begin
                    r_v[k] <= r_v[k-1];
                end
            end
        end
    end

    assign o_s_axis_tready = rdy[0];

    // ---------------- input register ----------------
    logic [N-1:0] r_br, r_bg, r_bb;
    logic [N-1:0] r_lr, r_lg, r_lb, r_la;
    logic [N-1:0] r_mask;

    always_ff @(posedge i_clk) begin
        if (en[ST_IN]) begin
            r_br   <= i_s_axis_tdata[0*N +: N];
            r_bg   <= i_s_axis_tdata[1*N +: N];
            r_bb   <= i_s_axis_tdata[2*N +: N];
            r_lr   <= i_s_axis_tdata[4*N +: N];
            r_lg   <= i_s_axis_tdata[5*N +: N];
            r_lb   <= i_s_axis_tdata[6*N +: N];
            r_la   <= i_s_axis_tdata[7*N +: N];
            r_mask <= i_s_axis_tdata[8*N +: N];
        end
    end

    // base alpha and last flag ride along the whole pipeline
    logic [N-1:0] r_ab   [0:L-1];
    logic         r_last [0:L-1];

    for (genvar k = 0; k < L; k++) begin : g_side
        if (k == 0) begin : g_first
            always_ff @(posedge i_clk) begin
                if (en[k]) begin
                    r_ab[k]   <= i_s_axis_tdata[3*N +: N];
                    r_last[k] <= i_s_axis_tlast;
                end
            end
        end else begin : g_next
            always_ff @(posedge i_clk) begin
                if (en[k]) begin
                    r_ab[k]   <= r_ab[k-1];
                    r_last[k] <= r_last[k-1];
                end
            end
        end
    end

    // ---------------- alpha path ----------------
    logic [N-1:0] w_ca;
    logic [N-1:0] w_na;
    logic [N-1:0] w_ca6;

    sba_alpha #(.CHANNEL_BITS(N)) u_alpha (
        .i_clk         (i_clk),
        .i_en          (en[ST_NA:ST_MUL]),
        .i_opacity     (r_opacity),
        .i_mask_en     (r_mask_en),
        .i_base_alpha  (r_ab[ST_IN]),
        .i_layer_alpha (r_la),
        .i_mask        (r_mask),
        .o_ca          (w_ca),
        .o_na          (w_na),
        .o_ca_na       (w_ca6)
    );

    // new alpha follows the word through the divider; pass flag to the end
    logic [L-3:ST_DIV][N-1:0]  r_na;
    logic [L-3:ST_NA][N-1:0]   na_pipe;
    logic [L-2:ST_DIV]         r_pass;

    always_ff @(posedge i_clk) begin
        if (en[ST_DIV]) begin
            r_na[ST_DIV]   <= w_na;
            r_pass[ST_DIV] <= (w_ca6 == '0) || (w_na == '0);
        end
        for (int k = ST_DIV + 1; k <= L - 3; k++) begin
            if (en[k]) begin
                r_na[k] <= r_na[k-1];
            end
        end
        for (int k = ST_DIV + 1; k <= L - 2; k++) begin
            if (en[k]) begin
                r_pass[k] <= r_pass[k-1];
            end
        end
    end

    assign na_pipe = {r_na, w_na};

    // ---------------- colour lanes ----------------
    logic [N-1:0] out_r, out_g, out_b;

    sba_chan #(.CHANNEL_BITS(N), .STAGES(L)) u_red (
        .i_clk     (i_clk),
        .i_en      (en[L-1:1]),
        .i_base    (r_br),
        .i_layer   (r_lr),
        .i_ca      (w_ca),
        .i_na_pipe (na_pipe),
        .i_pass    (r_pass[L-2]),
        .o_out     (out_r)
    );

    sba_chan #(.CHANNEL_BITS(N), .STAGES(L)) u_green (
        .i_clk     (i_clk),
        .i_en      (en[L-1:1]),
        .i_base    (r_bg),
        .i_layer   (r_lg),
        .i_ca      (w_ca),
        .i_na_pipe (na_pipe),
        .i_pass    (r_pass[L-2]),
        .o_out     (out_g)
    );

    sba_chan #(.CHANNEL_BITS(N), .STAGES(L)) u_blue (
        .i_clk     (i_clk),
        .i_en      (en[L-1:1]),
        .i_base    (r_bb),
        .i_layer   (r_lb),
        .i_ca      (w_ca),
        .i_na_pipe (na_pipe),
        .i_pass    (r_pass[L-2]),
        .o_out     (out_b)
    );

    // ---------------- output ----------------
    assign o_m_axis_tvalid = r_v[L-1];
    assign o_m_axis_tdata  = OUT_W'({r_ab[L-1], out_b, out_g, out_r});
    assign o_m_axis_tlast  = r_last[L-1];

    // ---------------- checks ----------------
    logic in_acc;
    logic out_acc;

    assign in_acc  = i_s_axis_tvalid && o_s_axis_tready;
    assign out_acc = o_m_axis_tvalid && i_m_axis_tready;

    // input stalls only with every stage full and the output held
    a_full_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_s_axis_tready |-> ((&r_v) && !i_m_axis_tready))
        else $error("input stalled while the pipeline has a free stage");

    // words are neither lost nor duplicated inside the pipeline
    a_conserve: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) |-> ($countones(r_v) == $past($countones(r_v))
            + int'($past(in_acc)) - int'($past(out_acc))))
        else $error("pipeline occupancy does not match accepted and delivered words");

    // composite alpha never exceeds new alpha, so the quotient fits
    a_ca_le_na: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v[ST_NA] |-> (w_ca6 <= w_na))
        else $error("composite alpha above new alpha");

endmodule

### sv/sba_div_stage.sv
// ----------------------------------------------------------------------------
// sba_div_stage - one restoring division step
// Shifts one dividend bit into the partial remainder, subtracts the divisor
// when it fits and shifts the quotient bit in. Registered.
// ----------------------------------------------------------------------------
module sba_div_stage #(
    parameter int CHANNEL_BITS = 16
) (
    input  logic                    i_clk,
    input  logic                    i_en,
    input  logic [CHANNEL_BITS-1:0] i_rem,
    input  logic [CHANNEL_BITS-1:0] i_dq,
    input  logic [CHANNEL_BITS-1:0] i_den,
    output logic [CHANNEL_BITS-1:0] o_rem,
    output logic [CHANNEL_BITS-1:0] o_dq
);

    localparam int N = CHANNEL_BITS;

    logic [N:0]   trial;
    logic [N:0]   diff;
    logic         fits;
    logic [N-1:0] n_rem;
    logic [N-1:0] n_dq;
    logic [N-1:0] r_rem;
    logic [N-1:0] r_dq;

    always_comb begin
        trial = {i_rem, i_dq[N-1]};
        diff  = trial - {1'b0, i_den};
        fits  = (trial >= {1'b0, i_den});
        n_rem = fits ? diff[N-1:0] : trial[N-1:0];
        n_dq  = {i_dq[N-2:0], fits};
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem <= n_rem;
            r_dq  <= n_dq;
        end
    end

    assign o_rem = r_rem;
    assign o_dq  = r_dq;

endmodule

### sv/sba_alpha.sv
// ----------------------------------------------------------------------------
// sba_alpha - composite and new alpha pipeline
// Computes the composite alpha (min alpha * opacity, optionally * mask) and
// the new alpha over six register stages.
// ----------------------------------------------------------------------------
module sba_alpha #(
    parameter int CHANNEL_BITS = 16
) (
    input  logic                                i_clk,
    input  logic [sba_pkg::ST_NA:sba_pkg::ST_MUL] i_en,
    input  logic [CHANNEL_BITS-1:0]             i_opacity,
    input  logic                                i_mask_en,
    input  logic [CHANNEL_BITS-1:0]             i_base_alpha,
    input  logic [CHANNEL_BITS-1:0]             i_layer_alpha,
    input  logic [CHANNEL_BITS-1:0]             i_mask,
    output logic [CHANNEL_BITS-1:0]             o_ca,
    output logic [CHANNEL_BITS-1:0]             o_na,
    output logic [CHANNEL_BITS-1:0]             o_ca_na
);

    import sba_pkg::*;

    localparam int N = CHANNEL_BITS;
    localparam int P = 2 * CHANNEL_BITS;
    localparam logic [N-1:0] ONE  = {N{1'b1}};
    localparam logic [N-1:0] HALF = {1'b0, {(N-1){1'b1}}};

    // rounded p / ONE, exact: p = hi*ONE + (hi + lo)
    function automatic logic [N-1:0] f_div_one(input logic [P-1:0] p);
        logic [P-1:0] s;
        logic [N:0]   u;
        logic [N-1:0] q;
        s = p + P'(HALF);
        u = {1'b0, s[P-1:N]} + {1'b0, s[N-1:0]};
        if (u >= {ONE, 1'b0}) begin
            q = s[P-1:N] + N'(2);
        end else if (u >= {1'b0, ONE}) begin
            q = s[P-1:N] + N'(1);
        end else begin
            q = s[P-1:N];
        end
        return q;
    endfunction

    logic [N-1:0] min_alpha;
    logic [P-1:0] r_m1;
    logic [N-1:0] r_ab1, r_ab2, r_ab3, r_ab4, r_ab5;
    logic [N-1:0] r_mask1, r_mask2;
    logic [N-1:0] r_ca0, r_ca3, r_ca, r_ca5, r_ca6;
    logic [P-1:0] r_m2, r_m3;
    logic [N-1:0] r_na;

    assign min_alpha = (i_base_alpha < i_layer_alpha) ? i_base_alpha : i_layer_alpha;

    always_ff @(posedge i_clk) begin
        if (i_en[ST_MUL]) begin
            r_m1    <= P'(min_alpha) * P'(i_opacity);
            r_ab1   <= i_base_alpha;
            r_mask1 <= i_mask;
        end
        if (i_en[ST_CA0]) begin
            r_ca0   <= f_div_one(r_m1);
            r_ab2   <= r_ab1;
            r_mask2 <= r_mask1;
        end
        if (i_en[ST_MSK]) begin
            r_m2  <= P'(r_ca0) * P'(r_mask2);
            r_ca3 <= r_ca0;
            r_ab3 <= r_ab2;
        end
        if (i_en[ST_CA]) begin
            r_ca  <= i_mask_en ? f_div_one(r_m2) : r_ca3;
            r_ab4 <= r_ab3;
        end
        if (i_en[ST_NAM]) begin
            r_m3  <= P'(ONE - r_ab4) * P'(r_ca);
            r_ca5 <= r_ca;
            r_ab5 <= r_ab4;
        end
        if (i_en[ST_NA]) begin
            // never exceeds ONE: the product term is at most ONE - base alpha
            r_na  <= r_ab5 + f_div_one(r_m3);
            r_ca6 <= r_ca5;
        end
    end

    assign o_ca    = r_ca;
    assign o_na    = r_na;
    assign o_ca_na = r_ca6;

endmodule

### sv/sba_chan.sv
// ----------------------------------------------------------------------------
// sba_chan - one colour channel of the screen blend
// Screen value, difference to base, scaling by composite alpha, division by
// the new alpha one quotient bit per stage, then add, saturate and select.
// ----------------------------------------------------------------------------
module sba_chan #(
    parameter int CHANNEL_BITS = 16,
    parameter int STAGES       = CHANNEL_BITS + 9
) (
    input  logic                                            i_clk,
    input  logic [STAGES-1:1]                               i_en,
    input  logic [CHANNEL_BITS-1:0]                         i_base,
    input  logic [CHANNEL_BITS-1:0]                         i_layer,
    input  logic [CHANNEL_BITS-1:0]                         i_ca,
    input  logic [STAGES-3:sba_pkg::ST_NA][CHANNEL_BITS-1:0] i_na_pipe,
    input  logic                                            i_pass,
    output logic [CHANNEL_BITS-1:0]                         o_out
);

    import sba_pkg::*;

    localparam int N = CHANNEL_BITS;
    localparam int P = 2 * CHANNEL_BITS;
    localparam int L = STAGES;
    localparam logic [N-1:0] ONE  = {N{1'b1}};
    localparam logic [N-1:0] HALF = {1'b0, {(N-1){1'b1}}};

    function automatic logic [N-1:0] f_div_one(input logic [P-1:0] p);
        logic [P-1:0] s;
        logic [N:0]   u;
        logic [N-1:0] q;
        s = p + P'(HALF);
        u = {1'b0, s[P-1:N]} + {1'b0, s[N-1:0]};
        if (u >= {ONE, 1'b0}) begin
            q = s[P-1:N] + N'(2);
        end else if (u >= {1'b0, ONE}) begin
            q = s[P-1:N] + N'(1);
        end else begin
            q = s[P-1:N];
        end
        return q;
    endfunction

    logic [N-1:0] r_a [1:L-2];
    logic [P-1:0] r_p;
    logic [N-1:0] r_scr;
    logic [N-1:0] r_diff, r_diff4;
    logic [P-1:0] r_prod, r_prod6;
    logic [P-1:0] r_dvd;
    logic [N-1:0] r_out;
    logic [N-1:0] dv_rem [0:N-1];
    logic [N-1:0] dv_dq  [0:N];
    logic [N:0]   sum;

    // base value travels beside the item
    for (genvar k = 1; k <= L - 2; k++) begin : g_base
        if (k == 1) begin : g_first
            always_ff @(posedge i_clk) begin
                if (i_en[k]) begin
                    r_a[k] <= i_base;
                end
            end
        end else begin : g_next
            always_ff @(posedge i_clk) begin
                if (i_en[k]) begin
                    r_a[k] <= r_a[k-1];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en[ST_MUL]) begin
            r_p <= P'(ONE - i_base) * P'(ONE - i_layer);
        end
        if (i_en[ST_CA0]) begin
            r_scr <= ONE - f_div_one(r_p);
        end
        if (i_en[ST_MSK]) begin
            r_diff <= (r_scr >= r_a[ST_CA0]) ? (r_scr - r_a[ST_CA0]) : '0;
        end
        if (i_en[ST_CA]) begin
            r_diff4 <= r_diff;
        end
        if (i_en[ST_NAM]) begin
            r_prod <= P'(r_diff4) * P'(i_ca);
        end
        if (i_en[ST_NA]) begin
            r_prod6 <= r_prod;
        end
        if (i_en[ST_DIV]) begin
            // add half the divisor so the quotient rounds, half up
            r_dvd <= r_prod6 + P'(i_na_pipe[ST_NA] >> 1);
        end
    end

    assign dv_rem[0] = r_dvd[P-1:N];
    assign dv_dq[0]  = r_dvd[N-1:0];

    for (genvar j = 0; j < N; j++) begin : g_div
        if (j < N - 1) begin : g_mid
            sba_div_stage #(.CHANNEL_BITS(N)) u_step (
                .i_clk (i_clk),
                .i_en  (i_en[ST_DIV0 + j]),
                .i_rem (dv_rem[j]),
                .i_dq  (dv_dq[j]),
                .i_den (i_na_pipe[ST_DIV + j]),
                .o_rem (dv_rem[j+1]),
                .o_dq  (dv_dq[j+1])
            );
        end else begin : g_last
            sba_div_stage #(.CHANNEL_BITS(N)) u_step (
                .i_clk (i_clk),
                .i_en  (i_en[ST_DIV0 + j]),
                .i_rem (dv_rem[j]),
                .i_dq  (dv_dq[j]),
                .i_den (i_na_pipe[ST_DIV + j]),
                .o_rem (),
                .o_dq  (dv_dq[j+1])
            );
        end
    end

    assign sum = {1'b0, r_a[L-2]} + {1'b0, dv_dq[N]};

    always_ff @(posedge i_clk) begin
        if (i_en[L-1]) begin
            priority if (i_pass) begin
                r_out <= r_a[L-2];
            end else if (sum[N]) begin
                r_out <= ONE;
            end else begin
                r_out <= sum[N-1:0];
            end
        end
    end

    assign o_out = r_out;

endmodule
